// ----- sv/svdp_pkg.sv -----
// package for the sparse vector dot product: sizes, request and result types
package svdp_pkg;

  // storage and dimension limits
  localparam int unsigned MaxEntries = 256;
  localparam int unsigned Dim        = 1024;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned ValW  = 32;
  localparam int unsigned SumW  = 64;
  localparam int unsigned AddrW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);

  // vector select codes
  localparam logic KindFirst  = 1'b0;
  localparam logic KindSecond = 1'b1;

  // one input request
  typedef struct packed {
    logic                   kind;
    logic [IdxW-1:0]        feature_index;
    logic signed [ValW-1:0] feature_value;
    logic                   last;
  } in_t;

  // one result
  typedef struct packed {
    logic signed [SumW-1:0] dot_sum;
    logic                   saturated;
    logic                   dropped;
  } out_t;

  // one stored vector entry
  typedef struct packed {
    logic [IdxW-1:0]        index;
    logic signed [ValW-1:0] value;
  } entry_t;

endpackage

// ----- sv/sparse_vector_dot_product.sv -----
// sparse vector dot product: entry load, merge walk, saturating accumulate
// Loading accepts one request per cycle while idle; requests are stalled during a walk.
// The second vector's last request starts a merge walk through the one shared
// multiply-accumulate unit: an advancing step reads, then compares; a matching pair
// reads, compares and multiplies, then accumulates; a final read state does the end
// check, and the result is registered once no previous result is still held.
// Reset (asynchronous, active low) empties both vectors and clears the drop flag.
module sparse_vector_dot_product (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  svdp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output svdp_pkg::out_t  out_data_o
);
  import svdp_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StCmp  = 4'b0100,
    StAcc  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] first_cnt_q, first_cnt_d;
  logic [CntW-1:0] second_cnt_q, second_cnt_d;
  logic            drop_q, drop_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic signed [SumW-1:0] acc_q, acc_d;
  logic            sat_q, sat_d;
  logic signed [SumW-1:0] prod_q, prod_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  entry_t first_mem [MaxEntries];
  entry_t second_mem [MaxEntries];
  entry_t first_rd_q, second_rd_q;

  logic   in_acc;
  logic   idx_bad;
  logic   first_full, second_full;
  logic   wr_first, wr_second;
  logic   start_walk;
  logic   walk_done;
  logic   out_free;
  entry_t wr_entry;
  logic signed [SumW:0] sum_ext;

  assign in_acc      = in_valid_i && (state_q == StIdle);
  assign idx_bad     = int'(in_data_i.feature_index) >= int'(Dim);
  assign first_full  = int'(first_cnt_q) >= int'(MaxEntries);
  assign second_full = int'(second_cnt_q) >= int'(MaxEntries);
  assign wr_first    = in_acc && !idx_bad && (in_data_i.kind == KindFirst) && !first_full;
  assign wr_second   = in_acc && !idx_bad && (in_data_i.kind == KindSecond) && !second_full;
  assign start_walk  = in_acc && (in_data_i.kind == KindSecond) && in_data_i.last;
  assign walk_done   = (i_q >= first_cnt_q) || (j_q >= second_cnt_q);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign wr_entry    = '{index: in_data_i.feature_index, value: in_data_i.feature_value};

  // saturating sum of accumulator and registered product
  assign sum_ext = {acc_q[SumW-1], acc_q} + {prod_q[SumW-1], prod_q};

  // entry memories
  always_ff @(posedge clk_i) begin
    if (wr_first) begin
      first_mem[first_cnt_q[AddrW-1:0]] <= wr_entry;
    end
    if (wr_second) begin
      second_mem[second_cnt_q[AddrW-1:0]] <= wr_entry;
    end
    first_rd_q  <= first_mem[i_q[AddrW-1:0]];
    second_rd_q <= second_mem[j_q[AddrW-1:0]];
  end

  // sequencer and datapath next state
  always_comb begin
    state_d      = state_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    drop_d       = drop_q;
    i_d          = i_q;
    j_d          = j_q;
    acc_d        = acc_q;
    sat_d        = sat_q;
    prod_d       = prod_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (wr_first) begin
            first_cnt_d = first_cnt_q + 1'b1;
          end
          if (wr_second) begin
            second_cnt_d = second_cnt_q + 1'b1;
          end
          if (!wr_first && !wr_second) begin
            drop_d = 1'b1;
          end
          if (start_walk) begin
            i_d     = '0;
            j_d     = '0;
            acc_d   = '0;
            sat_d   = 1'b0;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        if (walk_done) begin
          if (out_free) begin
            out_d        = '{dot_sum: acc_q, saturated: sat_q, dropped: drop_q};
            out_valid_d  = 1'b1;
            first_cnt_d  = '0;
            second_cnt_d = '0;
            drop_d       = 1'b0;
            state_d      = StIdle;
          end
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (first_rd_q.index == second_rd_q.index) begin
          prod_d  = first_rd_q.value * second_rd_q.value;
          i_d     = i_q + 1'b1;
          j_d     = j_q + 1'b1;
          state_d = StAcc;
        end else if (first_rd_q.index > second_rd_q.index) begin
          j_d     = j_q + 1'b1;
          state_d = StRead;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = StRead;
        end
      end
      StAcc: begin
        if (sum_ext[SumW] != sum_ext[SumW-1]) begin
          sat_d = 1'b1;
          acc_d = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        end else begin
          acc_d = sum_ext[SumW-1:0];
        end
        state_d = StRead;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      drop_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      drop_q       <= drop_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // walk payload registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    acc_q  <= acc_d;
    sat_q  <= sat_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/svdp_checker.sv -----
// port-level checker for the sparse vector dot product, with its bind
module svdp_port_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_o,
  input  svdp_pkg::in_t   in_data_i,
  input  logic            out_valid_o,
  input  logic            out_stall_i,
  input  svdp_pkg::out_t  out_data_o
);
  import svdp_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // the second vector's last request starts the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.kind == KindSecond) && in_data_i.last
    |=> in_stall_o)
    else $error("walk did not start");

  // a first vector request only loads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.kind == KindFirst) |=> !in_stall_o)
    else $error("block busy after a load");

endmodule

bind sparse_vector_dot_product svdp_port_checker u_svdp_checker (.*);

// ----- dv/svdp_checker.sv -----
// checker for the sparse dot product: predicts each sum from accepted requests and compares
module svdp_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  svdp_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  svdp_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import svdp_pkg::*;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // shadow copy of both stored vectors
  entry_t      first_entries  [MaxEntries];
  entry_t      second_entries [MaxEntries];
  int unsigned first_len  = 0;
  int unsigned second_len = 0;
  bit          drop_seen  = 1'b0;

  out_t expected_results [$];
  int   fail_count = 0;

  // merge walk over the stored entries with a saturating accumulator
  function automatic out_t merge_dot();
    int unsigned             i;
    int unsigned             j;
    logic signed [SumW-1:0]  acc;
    logic signed [SumW-1:0]  prod;
    logic signed [SumW:0]    wide;
    out_t                    res;
    i   = 0;
    j   = 0;
    acc = '0;
    res = '0;
    while (i < first_len && j < second_len) begin
      if (first_entries[i].index == second_entries[j].index) begin
        prod = $signed(first_entries[i].value) * $signed(second_entries[j].value);
        wide = $signed({acc[SumW-1], acc}) + $signed({prod[SumW-1], prod});
        // sign bits disagree: the step left the 64-bit range
        if (wide[SumW] != wide[SumW-1]) begin
          res.saturated = 1'b1;
          acc = wide[SumW] ? SumMin : SumMax;
        end else begin
          acc = wide[SumW-1:0];
        end
        i++;
        j++;
      end else if (first_entries[i].index > second_entries[j].index) begin
        j++;
      end else begin
        i++;
      end
    end
    res.dot_sum = acc;
    res.dropped = drop_seen;
    return res;
  endfunction

  task automatic note_failure(input string what, input out_t want, input out_t got);
    if (fail_count < 10) begin
      $display("%0t: %s: expected sum %h sat %b drop %b, got sum %h sat %b drop %b",
               $time, what, want.dot_sum, want.saturated, want.dropped,
               got.dot_sum, got.saturated, got.dropped);
    end
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    in_t  req;
    out_t want;
    if (rst_ni) begin
      // store the accepted request in its vector, or drop it
      if (in_valid_i && !in_stall_i) begin
        req = in_data_i;
        if (req.feature_index >= Dim) begin
          drop_seen = 1'b1;
        end else if (req.kind == KindFirst) begin
          if (first_len < MaxEntries) begin
            first_entries[first_len] = {req.feature_index, req.feature_value};
            first_len++;
          end else begin
            drop_seen = 1'b1;
          end
        end else begin
          if (second_len < MaxEntries) begin
            second_entries[second_len] = {req.feature_index, req.feature_value};
            second_len++;
          end else begin
            drop_seen = 1'b1;
          end
        end
        // last request of the second vector starts the walk, even if dropped
        if (req.kind == KindSecond && req.last) begin
          expected_results.push_back(merge_dot());
          first_len  = 0;
          second_len = 0;
          drop_seen  = 1'b0;
        end
      end
      // compare the accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          note_failure("result with none expected", '0, out_data_i);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.dot_sum !== want.dot_sum ||
              out_data_i.saturated !== want.saturated ||
              out_data_i.dropped !== want.dropped) begin
            note_failure("result mismatch", want, out_data_i);
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_results.size();
  end

endmodule

// ----- dv/testbench.sv -----
// top of the sparse dot product testbench: clock, reset, request stimulus and verdict
module testbench;
  import svdp_pkg::*;

  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] ValOne = 32'h0001_0000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int   fail_count;
  int   pending_results;
  int   sent_count = 0;
  bit   hold_done  = 1'b0;
  logic calm;

  // a stretch of requests with no idling on either side
  assign calm = (sent_count >= 900) && (sent_count < 1200);

  sparse_vector_dot_product uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  svdp_checker dot_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // value mix: extremes, zero, minus one lsb, small and full range
  function automatic logic [ValW-1:0] pick_value(input bit heavy);
    logic [31:0] bits;
    bits = $urandom;
    if (heavy) return bits[0] ? ValMax : ValMin;
    case ($urandom_range(0, 9)) inside
      0: return ValMax;
      1: return ValMin;
      2: return '0;
      3: return '1;
      [4:5]: return {{(ValW-18){bits[17]}}, bits[17:0]};
      default: return bits;
    endcase
  endfunction

  // offer one request, with an occasional gap before it, until it is taken
  task automatic send_entry(input logic kind, input logic [IdxW-1:0] index,
                            input logic [ValW-1:0] value, input logic last);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {kind, index, value, last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // one vector, ascending indices with rare repeats unless scrambled
  task automatic send_vector(input logic kind, input int len, input int gap,
                             input bit scramble, input bit heavy);
    int unsigned     idx;
    logic [IdxW-1:0] index_bits;
    idx = $urandom_range(0, gap);
    for (int n = 0; n < len; n++) begin
      index_bits = scramble ? IdxW'($urandom) : IdxW'(idx);
      send_entry(kind, index_bits, pick_value(heavy), n == len - 1);
      if ($urandom_range(0, 15) != 0) idx = idx + 1 + $urandom_range(0, gap);
      if (idx > Dim - 1) idx = Dim - 1;
    end
  endtask

  // result side: random stalls and one long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= 250) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      out_stall <= !calm && $urandom_range(0, 99) < 14;
    end
  end

  initial begin
    int          set_no;
    int          gap;
    bit          heavy;
    bit          scramble;
    logic [31:0] noise;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty first vector gives a zero sum
    send_entry(KindSecond, 10'd5, ValOne, 1'b1);

    // clamps high twice, then a negative product pulls the sum back in range
    send_entry(KindFirst, 10'd0, ValMax, 1'b0);
    send_entry(KindFirst, 10'd1, ValMax, 1'b0);
    send_entry(KindFirst, 10'd2, ValMin, 1'b0);
    send_entry(KindFirst, 10'd3, ValMin, 1'b0);
    send_entry(KindFirst, 10'd1023, ValMin, 1'b1);
    send_entry(KindSecond, 10'd0, ValMax, 1'b0);
    send_entry(KindSecond, 10'd1, ValMax, 1'b0);
    send_entry(KindSecond, 10'd2, ValMin, 1'b0);
    send_entry(KindSecond, 10'd3, ValMin, 1'b0);
    send_entry(KindSecond, 10'd1023, ValMax, 1'b1);

    // clamps low
    send_entry(KindFirst, 10'd10, ValMin, 1'b0);
    send_entry(KindFirst, 10'd11, ValMin, 1'b0);
    send_entry(KindFirst, 10'd12, ValMin, 1'b1);
    send_entry(KindSecond, 10'd10, ValMax, 1'b0);
    send_entry(KindSecond, 10'd11, ValMax, 1'b0);
    send_entry(KindSecond, 10'd12, ValMax, 1'b1);

    // unsorted first vector: the walk follows stored order
    send_entry(KindFirst, 10'd900, '1, 1'b0);
    send_entry(KindFirst, 10'd3, 32'h0002_0000, 1'b1);
    send_entry(KindSecond, 10'd3, 32'h0003_0000, 1'b0);
    send_entry(KindSecond, 10'd900, '1, 1'b1);

    // random sets, mostly well formed
    set_no = 0;
    while (sent_count < 1650) begin
      if (set_no == 100) begin
        // both vectors overflow; the second's dropped last request still starts the walk
        send_vector(KindFirst, MaxEntries + 1, 2, 1'b0, 1'b0);
        send_vector(KindSecond, MaxEntries + 1, 2, 1'b0, 1'b0);
      end else if ($urandom_range(0, 99) < 8) begin
        // noise: random vector select, indices and last marks
        repeat ($urandom_range(1, 10)) begin
          noise = $urandom;
          send_entry(noise[0], noise[10:1], pick_value(1'b0), noise[12:11] == 2'b00);
        end
      end else begin
        heavy    = $urandom_range(0, 9) == 0;
        scramble = $urandom_range(0, 9) == 0;
        gap      = heavy ? 0 : $urandom_range(0, 6);
        send_vector(KindFirst, $urandom_range(0, 10), gap, scramble, heavy);
        send_vector(KindSecond, $urandom_range(1, 10), gap, scramble, heavy);
      end
      set_no++;
    end
    in_valid <= 1'b0;

    // drain outstanding sums, then a short quiet tail
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
